// ===== rtl/qtpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the three-point quadratic fit.
// Used by the channel interfaces, the multiplier and divider chains and the top level.
package qtpf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int EXT_W      = DATA_WIDTH + 1;
   localparam int PROD_W     = 2 * DATA_WIDTH + 2;
   localparam int WIDE_W     = 6 * DATA_WIDTH + 8;
   localparam int DIG_W      = 8;
   localparam int MAG_A_W    = 4 * DATA_WIDTH;
   localparam int MUL_CELLS  = (3 * DATA_WIDTH + 8 + DIG_W - 1) / DIG_W;
   localparam int MAG_B_W    = MUL_CELLS * DIG_W;
   localparam int MUL_LAT    = MUL_CELLS + 2;
   localparam int DIV_LAT    = DATA_WIDTH + 3;
   localparam int PIPE_DEPTH = 2 * MUL_LAT + DIV_LAT + 5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_FLAT     = 2'd2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [EXT_W-1:0]      ext_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;
   typedef logic [WIDE_W-1:0]            mag_type;

   typedef struct packed {
      logic                 neg;
      mag_type              acc;
      mag_type              amag;
      logic [MAG_B_W-1:0]   bmag;
   } mul_stage_type;

   typedef struct packed {
      logic                  neg;
      logic                  over;
      logic [DATA_WIDTH-1:0] quo;
      mag_type               rem;
      mag_type               dsh;
      mag_type               dmag;
   } div_stage_type;

   typedef struct packed {
      data_type value;
      logic     sat;
   } div_result_type;

   function automatic mag_type wide_abs(input wide_type v);
      return v[WIDE_W-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

endpackage

// ===== rtl/qtpf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the point triples and the fit results.
// Depends on qtpf_pkg for the field types.
interface qtpf_req_if import qtpf_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type x_first;
   data_type y_first;
   data_type x_second;
   data_type y_second;
   data_type x_third;
   data_type y_third;

   modport source (output valid, x_first, y_first, x_second, y_second, x_third, y_third,
                   input ready);
   modport sink (input valid, x_first, y_first, x_second, y_second, x_third, y_third,
                 output ready);
endinterface

interface qtpf_rsp_if import qtpf_pkg::*; ();
   logic       valid;
   logic       ready;
   data_type   coef_square;
   data_type   coef_linear;
   data_type   coef_const;
   data_type   vertex_x;
   data_type   vertex_y;
   logic [1:0] fit_status;
   logic       saturated;

   modport source (output valid, coef_square, coef_linear, coef_const, vertex_x, vertex_y,
                   fit_status, saturated, input ready);
   modport sink (input valid, coef_square, coef_linear, coef_const, vertex_x, vertex_y,
                 fit_status, saturated, output ready);
endinterface

// ===== rtl/qtpf_mul_cell.sv =====
`timescale 1ns / 1ps
// One cell of the wide multiplier chain: adds the multiplicand times one digit.
// Depends on qtpf_pkg.
module qtpf_mul_cell import qtpf_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  mul_stage_type prev_stage,
   output mul_stage_type next_stage
);

   mul_stage_type cell_ff, cell_in;

   always_comb begin
      cell_in      = prev_stage;
      cell_in.acc  = prev_stage.acc + mag_type'(prev_stage.amag * prev_stage.bmag[DIG_W-1:0]);
      cell_in.amag = prev_stage.amag << DIG_W;
      cell_in.bmag = prev_stage.bmag >> DIG_W;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign next_stage = cell_ff;

endmodule

// ===== rtl/qtpf_mul.sv =====
`timescale 1ns / 1ps
// Pipelined signed wide multiplier built from a chain of digit cells.
// Depends on qtpf_pkg and qtpf_mul_cell.
module qtpf_mul import qtpf_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  wide_type mul_a,
   input  wide_type mul_b,
   output wide_type product
);

   mul_stage_type head_ff, head_in;
   mul_stage_type chain [MUL_CELLS+1];
   wide_type      product_ff, product_in;
   mag_type       a_abs, b_abs;

   always_comb begin
      a_abs        = wide_abs(mul_a);
      b_abs        = wide_abs(mul_b);
      head_in.neg  = mul_a[WIDE_W-1] ^ mul_b[WIDE_W-1];
      head_in.acc  = '0;
      head_in.amag = mag_type'(a_abs[MAG_A_W-1:0]);
      head_in.bmag = b_abs[MAG_B_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar k = 0; k < MUL_CELLS; k++) begin : g_cell
      qtpf_mul_cell u_cell (
         .clock      (clock),
         .en         (en),
         .prev_stage (chain[k]),
         .next_stage (chain[k+1])
      );
   end

   assign product_in = chain[MUL_CELLS].neg ? -wide_type'(chain[MUL_CELLS].acc)
                                            : wide_type'(chain[MUL_CELLS].acc);

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/qtpf_div_cell.sv =====
`timescale 1ns / 1ps
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on qtpf_pkg.
module qtpf_div_cell import qtpf_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  div_stage_type prev_stage,
   output div_stage_type next_stage
);

   div_stage_type cell_ff, cell_in;

   always_comb begin
      cell_in = prev_stage;
      if (prev_stage.rem >= prev_stage.dsh) begin
         cell_in.rem = prev_stage.rem - prev_stage.dsh;
         cell_in.quo = {prev_stage.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
         cell_in.quo = {prev_stage.quo[DATA_WIDTH-2:0], 1'b0};
      end
      cell_in.dsh = prev_stage.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign next_stage = cell_ff;

endmodule

// ===== rtl/qtpf_div.sv =====
`timescale 1ns / 1ps
// Pipelined signed divider with round to nearest, ties away from zero, and saturation.
// Depends on qtpf_pkg and qtpf_div_cell.
module qtpf_div import qtpf_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  wide_type       dividend,
   input  wide_type       divisor,
   output div_result_type quotient
);

   typedef logic [DATA_WIDTH:0] qmag_type;

   logic           neg_ff, neg_in;
   mag_type        nmag_ff, nmag_in;
   mag_type        dmag_ff, dmag_in;
   div_stage_type  head_ff, head_in;
   div_stage_type  chain [DATA_WIDTH+1];
   div_stage_type  tail;
   div_result_type result_ff, result_in;
   logic           round_up, clip;
   qmag_type       rounded, limit, mag, neg_mag;

   always_comb begin
      neg_in  = dividend[WIDE_W-1] ^ divisor[WIDE_W-1];
      nmag_in = wide_abs(dividend);
      dmag_in = wide_abs(divisor);
   end

   always_comb begin
      head_in.neg  = neg_ff;
      head_in.over = (nmag_ff >> DATA_WIDTH) >= dmag_ff;
      head_in.quo  = '0;
      head_in.rem  = nmag_ff;
      head_in.dsh  = dmag_ff << (DATA_WIDTH - 1);
      head_in.dmag = dmag_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= neg_in;
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
      qtpf_div_cell u_cell (
         .clock      (clock),
         .en         (en),
         .prev_stage (chain[k]),
         .next_stage (chain[k+1])
      );
   end

   always_comb begin
      tail     = chain[DATA_WIDTH];
      round_up = {tail.rem, 1'b0} >= {1'b0, tail.dmag};
      rounded  = {1'b0, tail.quo} + qmag_type'(round_up);
      limit    = {2'b01, {(DATA_WIDTH-1){1'b0}}} - qmag_type'(!tail.neg);
      clip     = tail.over || (rounded > limit);
      mag      = clip ? limit : rounded;
      neg_mag  = -mag;
      result_in.value = tail.neg ? data_type'(neg_mag[DATA_WIDTH-1:0])
                                 : data_type'(mag[DATA_WIDTH-1:0]);
      result_in.sat   = clip;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign quotient = result_ff;

endmodule

// ===== rtl/quadratic_three_point_fit.sv =====
`timescale 1ns / 1ps
// Top level of the three-point quadratic fit: exact Cramer numerators, wide
// multiplier chains, divider chains and a two-entry output buffer.
// Depends on qtpf_pkg, qtpf_ifs, qtpf_mul and qtpf_div.
//
//   channel   direction  transfer                  contents
//   req_bus   in         valid & ready             three points, signed Q16.16
//   rsp_bus   out        valid & ready             a, b, c, vertex, status, saturated
//
// One transfer is taken each cycle while req_bus.ready is high; each result passes through the
// two multiplier chains in turn, then the divider chain of one cell per quotient bit and
// then the output buffer before it reaches rsp_bus.
// Reset clears only the valid bits of the pipeline and of the output buffer.
// The whole pipeline holds while the second output entry is full, so req_bus.ready
// is low in every cycle in which a result waits with a second one behind it.
module quadratic_three_point_fit import qtpf_pkg::*; (
   input logic       clock,
   input logic       reset,
   qtpf_req_if.sink   req_bus,
   qtpf_rsp_if.source rsp_bus
);

   typedef struct packed {
      wide_type a;
      wide_type b;
      wide_type c;
      wide_type p;
      logic     sing;
      logic     flat;
   } coef_set_type;

   typedef struct packed {
      data_type   coef_square;
      data_type   coef_linear;
      data_type   coef_const;
      data_type   vertex_x;
      data_type   vertex_y;
      logic [1:0] fit_status;
      logic       saturated;
   } result_type;

   logic                  en, push, pop;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   data_type x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   data_type x1_s2_ff, y1_s2_ff, x2_s2_ff, y2_s2_ff, x3_s2_ff, y3_s2_ff;
   ext_type  d12_ff, d13_ff, d23_ff, s12_ff, s13_ff, s23_ff;
   ext_type  d23_s3_ff, s12_s3_ff, s13_s3_ff, s23_s3_ff;
   prod_type p1_ff, t1_ff, u2_ff, t3_ff, xx12_ff, xx13_ff, xx23_ff;
   wide_type a_sum;
   wide_type a_dly_ff [MUL_LAT];

   wide_type pm, e1, e2, e3, f1, f2, f3;
   coef_set_type cs_ff, cs_in;
   coef_set_type cs_dly_ff [MUL_LAT];
   wide_type ac, bb, ap;

   wide_type num_a_ff, num_b_ff, num_c_ff, num_vx_ff, num_vy_ff;
   wide_type den_p_ff, den_vx_ff, den_vy_ff;
   logic [1:0] flag_dly_ff [DIV_LAT+1];

   div_result_type q_a, q_b, q_c, q_vx, q_vy;
   result_type result;
   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;

   assign en            = !skid_vld_ff;
   assign req_bus.ready = en;
   assign vld_in        = {vld_ff[PIPE_DEPTH-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_bus.x_first;
         y1_ff <= req_bus.y_first;
         x2_ff <= req_bus.x_second;
         y2_ff <= req_bus.y_second;
         x3_ff <= req_bus.x_third;
         y3_ff <= req_bus.y_third;

         x1_s2_ff <= x1_ff;
         y1_s2_ff <= y1_ff;
         x2_s2_ff <= x2_ff;
         y2_s2_ff <= y2_ff;
         x3_s2_ff <= x3_ff;
         y3_s2_ff <= y3_ff;
         d12_ff   <= ext_type'(x1_ff) - ext_type'(x2_ff);
         d13_ff   <= ext_type'(x1_ff) - ext_type'(x3_ff);
         d23_ff   <= ext_type'(x2_ff) - ext_type'(x3_ff);
         s12_ff   <= ext_type'(x1_ff) + ext_type'(x2_ff);
         s13_ff   <= ext_type'(x1_ff) + ext_type'(x3_ff);
         s23_ff   <= ext_type'(x2_ff) + ext_type'(x3_ff);

         p1_ff     <= prod_type'(d12_ff) * prod_type'(d13_ff);
         t1_ff     <= prod_type'(y1_s2_ff) * prod_type'(d23_ff);
         u2_ff     <= prod_type'(y2_s2_ff) * prod_type'(d13_ff);
         t3_ff     <= prod_type'(y3_s2_ff) * prod_type'(d12_ff);
         xx12_ff   <= prod_type'(x1_s2_ff) * prod_type'(x2_s2_ff);
         xx13_ff   <= prod_type'(x1_s2_ff) * prod_type'(x3_s2_ff);
         xx23_ff   <= prod_type'(x2_s2_ff) * prod_type'(x3_s2_ff);
         d23_s3_ff <= d23_ff;
         s12_s3_ff <= s12_ff;
         s13_s3_ff <= s13_ff;
         s23_s3_ff <= s23_ff;
      end
   end

   assign a_sum = wide_type'(t1_ff) - wide_type'(u2_ff) + wide_type'(t3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         a_dly_ff[0] <= a_sum;
         for (int k = 1; k < MUL_LAT; k++) begin
            a_dly_ff[k] <= a_dly_ff[k-1];
         end
      end
   end

   qtpf_mul u_mul_p (.clock(clock), .en(en), .mul_a(wide_type'(p1_ff)),
                     .mul_b(wide_type'(d23_s3_ff)), .product(pm));
   qtpf_mul u_mul_e1 (.clock(clock), .en(en), .mul_a(wide_type'(t1_ff)),
                      .mul_b(wide_type'(s23_s3_ff)), .product(e1));
   qtpf_mul u_mul_e2 (.clock(clock), .en(en), .mul_a(wide_type'(u2_ff)),
                      .mul_b(wide_type'(s13_s3_ff)), .product(e2));
   qtpf_mul u_mul_e3 (.clock(clock), .en(en), .mul_a(wide_type'(t3_ff)),
                      .mul_b(wide_type'(s12_s3_ff)), .product(e3));
   qtpf_mul u_mul_f1 (.clock(clock), .en(en), .mul_a(wide_type'(t1_ff)),
                      .mul_b(wide_type'(xx23_ff)), .product(f1));
   qtpf_mul u_mul_f2 (.clock(clock), .en(en), .mul_a(wide_type'(u2_ff)),
                      .mul_b(wide_type'(xx13_ff)), .product(f2));
   qtpf_mul u_mul_f3 (.clock(clock), .en(en), .mul_a(wide_type'(t3_ff)),
                      .mul_b(wide_type'(xx12_ff)), .product(f3));

   always_comb begin
      cs_in.a    = a_dly_ff[MUL_LAT-1];
      cs_in.b    = e2 - e1 - e3;
      cs_in.c    = f1 - f2 + f3;
      cs_in.p    = pm;
      cs_in.sing = (pm == '0);
      cs_in.flat = (a_dly_ff[MUL_LAT-1] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff        <= cs_in;
         cs_dly_ff[0] <= cs_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            cs_dly_ff[k] <= cs_dly_ff[k-1];
         end
      end
   end

   qtpf_mul u_mul_ac (.clock(clock), .en(en), .mul_a(cs_ff.c), .mul_b(cs_ff.a), .product(ac));
   qtpf_mul u_mul_bb (.clock(clock), .en(en), .mul_a(cs_ff.b), .mul_b(cs_ff.b), .product(bb));
   qtpf_mul u_mul_ap (.clock(clock), .en(en), .mul_a(cs_ff.p), .mul_b(cs_ff.a), .product(ap));

   always_ff @(posedge clock) begin
      if (en) begin
         num_a_ff  <= cs_dly_ff[MUL_LAT-1].a <<< (2 * FRAC_BITS);
         num_b_ff  <= cs_dly_ff[MUL_LAT-1].b <<< FRAC_BITS;
         num_c_ff  <= cs_dly_ff[MUL_LAT-1].c;
         num_vx_ff <= -cs_dly_ff[MUL_LAT-1].b;
         num_vy_ff <= (ac <<< 2) - bb;
         den_p_ff  <= cs_dly_ff[MUL_LAT-1].p;
         den_vx_ff <= cs_dly_ff[MUL_LAT-1].a <<< 1;
         den_vy_ff <= ap <<< 2;
         flag_dly_ff[0] <= {cs_dly_ff[MUL_LAT-1].sing, cs_dly_ff[MUL_LAT-1].flat};
         for (int k = 1; k <= DIV_LAT; k++) begin
            flag_dly_ff[k] <= flag_dly_ff[k-1];
         end
      end
   end

   qtpf_div u_div_a (.clock(clock), .en(en), .dividend(num_a_ff), .divisor(den_p_ff),
                     .quotient(q_a));
   qtpf_div u_div_b (.clock(clock), .en(en), .dividend(num_b_ff), .divisor(den_p_ff),
                     .quotient(q_b));
   qtpf_div u_div_c (.clock(clock), .en(en), .dividend(num_c_ff), .divisor(den_p_ff),
                     .quotient(q_c));
   qtpf_div u_div_vx (.clock(clock), .en(en), .dividend(num_vx_ff), .divisor(den_vx_ff),
                      .quotient(q_vx));
   qtpf_div u_div_vy (.clock(clock), .en(en), .dividend(num_vy_ff), .divisor(den_vy_ff),
                      .quotient(q_vy));

   always_comb begin
      result = '0;
      if (flag_dly_ff[DIV_LAT][1]) begin
         result.fit_status = STATUS_SINGULAR;
      end else begin
         result.coef_square = q_a.value;
         result.coef_linear = q_b.value;
         result.coef_const  = q_c.value;
         if (flag_dly_ff[DIV_LAT][0]) begin
            result.fit_status = STATUS_FLAT;
            result.saturated  = q_a.sat | q_b.sat | q_c.sat;
         end else begin
            result.fit_status = STATUS_OK;
            result.vertex_x   = q_vx.value;
            result.vertex_y   = q_vy.value;
            result.saturated  = q_a.sat | q_b.sat | q_c.sat | q_vx.sat | q_vy.sat;
         end
      end
   end

   assign push = en && vld_ff[PIPE_DEPTH-1];
   assign pop  = out_vld_ff && rsp_bus.ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || pop) begin
         out_vld_in = push;
         out_in     = result;
      end else if (push) begin
         skid_vld_in = 1'b1;
         skid_in     = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.coef_square = out_ff.coef_square;
   assign rsp_bus.coef_linear = out_ff.coef_linear;
   assign rsp_bus.coef_const  = out_ff.coef_const;
   assign rsp_bus.vertex_x    = out_ff.vertex_x;
   assign rsp_bus.vertex_y    = out_ff.vertex_y;
   assign rsp_bus.fit_status  = out_ff.fit_status;
   assign rsp_bus.saturated   = out_ff.saturated;

   // The second buffer entry only fills behind a waiting result.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("second output entry full while first is empty");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_bus.ready && !skid_vld_ff && push) |=> skid_vld_ff)
      else $error("result arriving behind a stalled transfer was not buffered");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.fit_status == STATUS_SINGULAR) |->
      (rsp_bus.coef_square == '0 && rsp_bus.coef_linear == '0 && rsp_bus.coef_const == '0
       && rsp_bus.vertex_x == '0 && rsp_bus.vertex_y == '0 && !rsp_bus.saturated))
      else $error("singular fit carries nonzero values");

   a_flat_vertex : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.fit_status == STATUS_FLAT) |->
      (rsp_bus.coef_square == '0 && rsp_bus.vertex_x == '0 && rsp_bus.vertex_y == '0))
      else $error("collinear fit carries a vertex or a leading coefficient");

endmodule

// ===== tb/quadratic_three_point_fit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of quadratic_three_point_fit: directed table, then random triples.
// Depends on qtpf_pkg, qtpf_ifs and the top level; predicts fits with exact wide integers where the table gives none.
module quadratic_three_point_fit_tb import qtpf_pkg::*; ();

   typedef logic signed [255:0] exact_type;

   typedef struct {
      data_type x1, y1, x2, y2, x3, y3;
   } triple_type;

   typedef struct {
      data_type   a, b, c, vx, vy;
      logic [1:0] status;
      logic       sat;
   } fit_type;

   typedef struct {
      triple_type pts;
      logic       typed;
      fit_type    fit;
   } row_type;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 430;
   localparam int LONG_STALL = 400;
   localparam data_type DMAX = 32'sh7fffffff;
   localparam data_type DMIN = 32'sh80000000;
   localparam data_type ONE = 32'sh00010000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   failures = 0;
   int   results_seen = 0;
   bit   feed_done = 1'b0;
   fit_type pending_fits[$];
   row_type directed_rows[$];

   qtpf_req_if req_bus ();
   qtpf_rsp_if rsp_bus ();

   quadratic_three_point_fit dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("quadratic_three_point_fit_tb: FAIL");
         $finish;
      end
   end

   // Quotient rounded to nearest, ties away from zero, clipped; bit 32 flags a clip.
   function automatic logic [32:0] rounded_quotient(input exact_type n, input exact_type d);
      logic      neg;
      exact_type mn, md, q, r, lim;
      logic      clip;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = mn / md;
      r = mn % md;
      if (2 * r >= md) q = q + 1;
      lim = neg ? (exact_type'(1) <<< 31) : ((exact_type'(1) <<< 31) - 1);
      clip = 1'b0;
      if (q > lim) begin
         q = lim;
         clip = 1'b1;
      end
      if (neg) q = -q;
      return {clip, q[31:0]};
   endfunction

   function automatic fit_type fit_parabola(input triple_type t);
      exact_type x1, y1, x2, y2, x3, y3, p, t1, t2, t3, ca, cb, cc;
      logic [32:0] q;
      fit_type f;
      x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
      f = '{default: 0};
      f.status = STATUS_OK;
      p = (x1 - x2) * (x1 - x3) * (x2 - x3);
      if (p == 0) begin
         f.status = STATUS_SINGULAR;
         return f;
      end
      t1 = y1 * (x2 - x3);
      t2 = -(y2 * (x1 - x3));
      t3 = y3 * (x1 - x2);
      ca = t1 + t2 + t3;
      cb = -(t1 * (x2 + x3) + t2 * (x1 + x3) + t3 * (x1 + x2));
      cc = t1 * x2 * x3 + t2 * x1 * x3 + t3 * x1 * x2;
      q = rounded_quotient(ca <<< 32, p);
      f.a = q[31:0]; f.sat = f.sat | q[32];
      q = rounded_quotient(cb <<< 16, p);
      f.b = q[31:0]; f.sat = f.sat | q[32];
      q = rounded_quotient(cc, p);
      f.c = q[31:0]; f.sat = f.sat | q[32];
      if (ca == 0) begin
         f.status = STATUS_FLAT;
      end else begin
         q = rounded_quotient(-cb, 2 * ca);
         f.vx = q[31:0]; f.sat = f.sat | q[32];
         q = rounded_quotient(4 * ca * cc - cb * cb, 4 * ca * p);
         f.vy = q[31:0]; f.sat = f.sat | q[32];
      end
      return f;
   endfunction

   function automatic data_type rand_word();
      return data_type'($urandom);
   endfunction

   function automatic data_type rand_near(input int span);
      return data_type'($urandom_range(0, 2 * span)) - data_type'(span);
   endfunction

   function automatic triple_type random_triple();
      triple_type t;
      data_type   m, k;
      int         pick;
      pick = $urandom_range(0, 9);
      t.x1 = rand_near(1 << 20); t.x2 = rand_near(1 << 20); t.x3 = rand_near(1 << 20);
      t.y1 = rand_near(1 << 22); t.y2 = rand_near(1 << 22); t.y3 = rand_near(1 << 22);
      case (pick)
         6: begin
            t.x1 = rand_word(); t.x2 = rand_word(); t.x3 = rand_word();
            t.y1 = rand_word(); t.y2 = rand_word(); t.y3 = rand_word();
         end
         7: begin
            if ($urandom_range(0, 1)) t.x2 = t.x1;
            else t.x3 = t.x2;
         end
         8, 9: begin
            t.x1 = rand_near(1 << 12); t.x2 = rand_near(1 << 12); t.x3 = rand_near(1 << 12);
            m = rand_near(64);
            k = rand_near(1 << 20);
            t.y1 = m * t.x1 + k; t.y2 = m * t.x2 + k; t.y3 = m * t.x3 + k;
            if (pick == 9) t.y2 = t.y2 + 1;
         end
         default: ;
      endcase
      return t;
   endfunction

   task automatic add_row(input triple_type t, input logic typed, input fit_type f);
      row_type r;
      r.pts = t;
      r.typed = typed;
      r.fit = f;
      directed_rows.push_back(r);
   endtask

   function automatic triple_type mk(input data_type x1, y1, x2, y2, x3, y3);
      triple_type t;
      t.x1 = x1; t.y1 = y1; t.x2 = x2; t.y2 = y2; t.x3 = x3; t.y3 = y3;
      return t;
   endfunction

   function automatic fit_type fit_of(input data_type a, b, c, vx, vy,
                                      input logic [1:0] s, input logic sat);
      fit_type f;
      f.a = a; f.b = b; f.c = c; f.vx = vx; f.vy = vy; f.status = s; f.sat = sat;
      return f;
   endfunction

   task automatic build_table();
      fit_type none;
      none = fit_of(0, 0, 0, 0, 0, STATUS_SINGULAR, 0);
      add_row(mk(0, 0, 0, 0, 0, 0), 1, none);
      add_row(mk(DMAX, DMAX, DMAX, DMIN, 0, 5), 1, none);
      add_row(mk(DMIN, DMIN, 7, DMAX, DMIN, 3), 1, none);
      add_row(mk(0, 0, ONE, ONE, 2 * ONE, 2 * ONE), 1,
              fit_of(0, ONE, 0, 0, 0, STATUS_FLAT, 0));
      add_row(mk(0, 5 * ONE, ONE, 5 * ONE, 2 * ONE, 5 * ONE), 1,
              fit_of(0, 0, 5 * ONE, 0, 0, STATUS_FLAT, 0));
      add_row(mk(-ONE, ONE, 0, 0, ONE, ONE), 1,
              fit_of(ONE, 0, 0, 0, 0, STATUS_OK, 0));
      add_row(mk(DMIN, DMIN, 0, DMAX, DMAX, DMIN), 0, none);
      add_row(mk(DMIN, DMAX, DMAX, DMIN, 0, DMAX), 0, none);
      add_row(mk(DMAX, DMAX, DMAX - 1, DMIN, DMAX - 2, DMAX), 0, none);
      add_row(mk(0, 0, 1, DMAX, 2, DMIN), 0, none);
      add_row(mk(DMIN, 0, DMIN + 1, 0, DMIN + 2, 1), 0, none);
      add_row(mk(0, 0, 1, 1, 2, 3), 0, none);
      add_row(mk(-3 * ONE, 2 * ONE, ONE, -ONE, 4 * ONE, 7 * ONE), 0, none);
      add_row(mk(100, 0, 200, 0, 300, 1), 0, none);
      add_row(mk(-1, -1, -2, -2, -3, -4), 0, none);
      add_row(mk(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
                 32'sh33333333, 32'shcccccccc), 0, none);
      add_row(mk(32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0, 32'sh0f0f0f0f,
                 32'shcccccccc, 32'sh33333333), 0, none);
      add_row(mk(ONE, DMAX, 2 * ONE, DMIN, 3 * ONE, DMAX), 0, none);
   endtask

   task automatic send_triple(input triple_type t, input fit_type f);
      int gap;
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_first <= t.x1; req_bus.y_first <= t.y1;
      req_bus.x_second <= t.x2; req_bus.y_second <= t.y2;
      req_bus.x_third <= t.x3; req_bus.y_third <= t.y3;
      do @(posedge clock); while (!req_bus.ready);
      pending_fits.push_back(f);
   endtask

   initial begin
      triple_type t;
      req_bus.valid = 1'b0;
      req_bus.x_first = '0; req_bus.y_first = '0;
      req_bus.x_second = '0; req_bus.y_second = '0;
      req_bus.x_third = '0; req_bus.y_third = '0;
      build_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_triple(directed_rows[i].pts,
                     directed_rows[i].typed ? directed_rows[i].fit
                                            : fit_parabola(directed_rows[i].pts));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         t = random_triple();
         send_triple(t, fit_parabola(t));
      end
      req_bus.valid <= 1'b0;
      feed_done = 1'b1;
   end

   initial begin
      int wait_cycles;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         wait_cycles = (results_seen == 60) ? LONG_STALL : $urandom_range(0, 18);
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      fit_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen <= results_seen + 1;
         if (pending_fits.size() == 0) begin
            $error("unexpected transfer on rsp_bus");
            failures++;
         end else begin
            e = pending_fits.pop_front();
            if (rsp_bus.coef_square !== e.a) begin
               $error("coef_square expected %0d actual %0d", e.a, rsp_bus.coef_square);
               failures++;
            end
            if (rsp_bus.coef_linear !== e.b) begin
               $error("coef_linear expected %0d actual %0d", e.b, rsp_bus.coef_linear);
               failures++;
            end
            if (rsp_bus.coef_const !== e.c) begin
               $error("coef_const expected %0d actual %0d", e.c, rsp_bus.coef_const);
               failures++;
            end
            if (rsp_bus.vertex_x !== e.vx) begin
               $error("vertex_x expected %0d actual %0d", e.vx, rsp_bus.vertex_x);
               failures++;
            end
            if (rsp_bus.vertex_y !== e.vy) begin
               $error("vertex_y expected %0d actual %0d", e.vy, rsp_bus.vertex_y);
               failures++;
            end
            if (rsp_bus.fit_status !== e.status) begin
               $error("fit_status expected %0d actual %0d", e.status, rsp_bus.fit_status);
               failures++;
            end
            if (rsp_bus.saturated !== e.sat) begin
               $error("saturated expected %0d actual %0d", e.sat, rsp_bus.saturated);
               failures++;
            end
         end
      end
   end

   initial begin
      wait (feed_done);
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (failures == 0 && pending_fits.size() == 0) begin
         $display("quadratic_three_point_fit_tb: PASS");
      end else begin
         $display("quadratic_three_point_fit_tb: FAIL");
      end
      $finish;
   end

endmodule
